### rtl/tarhw_pkg.sv
package tarhw_pkg;

    // Stream geometry
    localparam int BLOCK_BYTES      = 512;
    localparam int BLOCK_IDX_BITS   = 9;
    localparam int OFFSET_BITS      = 40;
    localparam int OFFSET_FIELD     = 40;
    localparam int SIZE_BITS        = 36;
    localparam int BLK_CNT_BITS     = 28;

    // Header layout
    localparam int SIZE_FIELD_START = 124;
    localparam int SIZE_FIELD_BYTES = 12;
    localparam int TYPE_BYTE_POS    = 156;

    typedef logic [BLOCK_IDX_BITS-1:0] blk_idx_t;
    typedef logic [OFFSET_BITS-1:0]    pos_t;
    typedef logic [OFFSET_FIELD-1:0]   off_t;
    typedef logic [SIZE_BITS-1:0]      size_t;
    typedef logic [BLK_CNT_BITS-1:0]   blk_cnt_t;

    localparam blk_idx_t BLOCK_LAST    = blk_idx_t'(BLOCK_BYTES - 1);
    localparam blk_idx_t SIZE_FIRST    = blk_idx_t'(SIZE_FIELD_START);
    localparam blk_idx_t SIZE_END      = blk_idx_t'(SIZE_FIELD_START + SIZE_FIELD_BYTES);
    localparam blk_idx_t TYPE_POS      = blk_idx_t'(TYPE_BYTE_POS);

    // Characters of interest
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_SEVEN  = 8'h37;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        KIND_REGULAR    = 3'd0,
        KIND_ZERO_END   = 3'd1,
        KIND_INPUT_END  = 3'd2,
        KIND_BAD_SIZE   = 3'd3,
        KIND_CUT_HEADER = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t kind;
        off_t  offset;
        size_t size;
        logic  last;
    } result_t;

    // Results caused by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } res_pair_t;

endpackage

### rtl/tarhw_parser.sv
module tarhw_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_input,
    output tarhw_pkg::res_pair_t  results
);

    tarhw_pkg::blk_idx_t byte_in_block_reg, byte_in_block_next;
    tarhw_pkg::pos_t     stream_position_reg, stream_position_next;
    tarhw_pkg::phase_t   phase_reg, phase_next;
    tarhw_pkg::blk_cnt_t payload_blocks_left_reg, payload_blocks_left_next;
    logic                block_all_zero_reg, block_all_zero_next;
    logic                zero_block_seen_reg, zero_block_seen_next;
    tarhw_pkg::size_t    size_acc_reg, size_acc_next;
    logic                size_digit_seen_reg, size_digit_seen_next;
    logic                size_closed_reg, size_closed_next;
    logic                size_bad_reg, size_bad_next;
    logic [7:0]          type_byte_reg, type_byte_next;

    // Header byte decode
    logic                in_field;
    logic                is_blank;
    logic                is_octal;
    logic                hz_all_zero;
    tarhw_pkg::size_t    hz_acc;
    logic                hz_digit_seen;
    logic                hz_closed;
    logic                hz_bad;
    logic [7:0]          hz_type;
    logic                block_end;
    tarhw_pkg::blk_cnt_t hz_blocks;
    tarhw_pkg::blk_cnt_t blocks_dec;
    tarhw_pkg::pos_t     pos_plus1;

    // End-of-header outcomes
    logic                end_zero_arch;
    logic                end_bad;
    logic                end_regular;

    // Field parser for one header byte
    always_comb
    begin
        in_field = (byte_in_block_reg >= tarhw_pkg::SIZE_FIRST)
                && (byte_in_block_reg < tarhw_pkg::SIZE_END)
                && !size_closed_reg && !size_bad_reg;
        is_blank = (data_byte == tarhw_pkg::CHAR_NUL) || (data_byte == tarhw_pkg::CHAR_SPACE);
        is_octal = (data_byte >= tarhw_pkg::CHAR_ZERO) && (data_byte <= tarhw_pkg::CHAR_SEVEN);

        hz_all_zero   = block_all_zero_reg && (data_byte == tarhw_pkg::CHAR_NUL);
        hz_acc        = size_acc_reg;
        hz_digit_seen = size_digit_seen_reg;
        hz_closed     = size_closed_reg;
        hz_bad        = size_bad_reg;
        hz_type       = type_byte_reg;

        if (in_field)
        begin
            if (is_blank)
            begin
                if (size_digit_seen_reg)
                    hz_closed = 1'b1;
            end
            else if (!is_octal)
            begin
                hz_bad = 1'b1;
            end
            else
            begin
                hz_acc        = {size_acc_reg[tarhw_pkg::SIZE_BITS-4:0], data_byte[2:0]};
                hz_digit_seen = 1'b1;
            end
        end

        if (byte_in_block_reg == tarhw_pkg::TYPE_POS)
            hz_type = data_byte;

        block_end  = (byte_in_block_reg == tarhw_pkg::BLOCK_LAST);
        // ceil(size / 512)
        hz_blocks  = tarhw_pkg::blk_cnt_t'(hz_acc[tarhw_pkg::SIZE_BITS-1:tarhw_pkg::BLOCK_IDX_BITS])
                   + tarhw_pkg::blk_cnt_t'(|hz_acc[tarhw_pkg::BLOCK_IDX_BITS-1:0]);
        blocks_dec = payload_blocks_left_reg - tarhw_pkg::blk_cnt_t'(1);
        pos_plus1  = stream_position_reg + tarhw_pkg::pos_t'(1);

        end_zero_arch = (phase_reg == tarhw_pkg::PH_HEADER) && block_end
                     && hz_all_zero && zero_block_seen_reg;
        end_bad       = (phase_reg == tarhw_pkg::PH_HEADER) && block_end
                     && !hz_all_zero && hz_bad;
        end_regular   = (phase_reg == tarhw_pkg::PH_HEADER) && block_end
                     && !hz_all_zero && !hz_bad
                     && ((hz_type == tarhw_pkg::CHAR_NUL) || (hz_type == tarhw_pkg::CHAR_ZERO));
    end

    // Next state
    always_comb
    begin
        byte_in_block_next       = byte_in_block_reg;
        stream_position_next     = stream_position_reg;
        phase_next               = phase_reg;
        payload_blocks_left_next = payload_blocks_left_reg;
        block_all_zero_next      = block_all_zero_reg;
        zero_block_seen_next     = zero_block_seen_reg;
        size_acc_next            = size_acc_reg;
        size_digit_seen_next     = size_digit_seen_reg;
        size_closed_next         = size_closed_reg;
        size_bad_next            = size_bad_reg;
        type_byte_next           = type_byte_reg;

        case (phase_reg)
            tarhw_pkg::PH_HEADER:
            begin
                if (block_end)
                begin
                    if (hz_all_zero)
                    begin
                        if (zero_block_seen_reg)
                            phase_next = tarhw_pkg::PH_DONE;
                        else
                            zero_block_seen_next = 1'b1;
                    end
                    else
                    begin
                        zero_block_seen_next = 1'b0;
                        if (hz_bad)
                        begin
                            phase_next = tarhw_pkg::PH_DONE;
                        end
                        else
                        begin
                            payload_blocks_left_next = hz_blocks;
                            if (hz_blocks != '0)
                                phase_next = tarhw_pkg::PH_PAYLOAD;
                        end
                    end
                    block_all_zero_next  = 1'b1;
                    size_acc_next        = '0;
                    size_digit_seen_next = 1'b0;
                    size_closed_next     = 1'b0;
                    size_bad_next        = 1'b0;
                    type_byte_next       = '0;
                end
                else
                begin
                    block_all_zero_next  = hz_all_zero;
                    size_acc_next        = hz_acc;
                    size_digit_seen_next = hz_digit_seen;
                    size_closed_next     = hz_closed;
                    size_bad_next        = hz_bad;
                    type_byte_next       = hz_type;
                end
            end
            tarhw_pkg::PH_PAYLOAD:
            begin
                if (block_end)
                begin
                    payload_blocks_left_next = blocks_dec;
                    if (blocks_dec == '0)
                        phase_next = tarhw_pkg::PH_HEADER;
                end
            end
            default:
            begin
            end
        endcase

        if (phase_next != tarhw_pkg::PH_DONE)
        begin
            byte_in_block_next   = byte_in_block_reg + tarhw_pkg::blk_idx_t'(1);
            stream_position_next = pos_plus1;
        end

        // Final byte re-arms the walker
        if (end_of_input)
        begin
            byte_in_block_next       = '0;
            stream_position_next     = '0;
            phase_next               = tarhw_pkg::PH_HEADER;
            payload_blocks_left_next = '0;
            block_all_zero_next      = 1'b1;
            zero_block_seen_next     = 1'b0;
            size_acc_next            = '0;
            size_digit_seen_next     = 1'b0;
            size_closed_next         = 1'b0;
            size_bad_next            = 1'b0;
            type_byte_next           = '0;
        end
    end

    // Results for this byte
    always_comb
    begin
        tarhw_pkg::result_t first;
        tarhw_pkg::result_t fin;
        logic               first_v;
        logic               fin_v;
        logic               ended_done;
        logic               cut_hdr;

        first_v    = end_zero_arch || end_bad || end_regular;
        first      = '0;
        if (end_regular)
        begin
            first.kind   = tarhw_pkg::KIND_REGULAR;
            first.offset = tarhw_pkg::off_t'(pos_plus1);
            first.size   = hz_acc;
        end
        else if (end_bad)
        begin
            first.kind = tarhw_pkg::KIND_BAD_SIZE;
        end
        else
        begin
            first.kind = tarhw_pkg::KIND_ZERO_END;
        end

        // Phase and block index as left by the byte, before re-arm
        ended_done = end_zero_arch || end_bad || (phase_reg == tarhw_pkg::PH_DONE);
        cut_hdr    = !ended_done
                  && (((phase_reg == tarhw_pkg::PH_HEADER) && !block_end)
                   || ((phase_reg == tarhw_pkg::PH_HEADER) && block_end
                       && (hz_all_zero || hz_blocks == '0) && 1'b0)
                   || ((phase_reg == tarhw_pkg::PH_PAYLOAD) && block_end
                       && (blocks_dec == '0) && 1'b0));
        fin_v      = end_of_input && !ended_done;
        fin        = '0;
        fin.kind   = cut_hdr ? tarhw_pkg::KIND_CUT_HEADER : tarhw_pkg::KIND_INPUT_END;
        fin.last   = 1'b1;

        results       = '0;
        results.count = 2'(first_v) + 2'(fin_v);
        if (first_v)
        begin
            results.r0      = first;
            results.r0.last = !fin_v;
            results.r1      = fin;
        end
        else
        begin
            results.r0 = fin;
        end
    end

    // Walker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_block_reg       <= '0;
            stream_position_reg     <= '0;
            phase_reg               <= tarhw_pkg::PH_HEADER;
            payload_blocks_left_reg <= '0;
            block_all_zero_reg      <= 1'b1;
            zero_block_seen_reg     <= 1'b0;
            size_acc_reg            <= '0;
            size_digit_seen_reg     <= 1'b0;
            size_closed_reg         <= 1'b0;
            size_bad_reg            <= 1'b0;
            type_byte_reg           <= '0;
        end
        else if (accept)
        begin
            byte_in_block_reg       <= byte_in_block_next;
            stream_position_reg     <= stream_position_next;
            phase_reg               <= phase_next;
            payload_blocks_left_reg <= payload_blocks_left_next;
            block_all_zero_reg      <= block_all_zero_next;
            zero_block_seen_reg     <= zero_block_seen_next;
            size_acc_reg            <= size_acc_next;
            size_digit_seen_reg     <= size_digit_seen_next;
            size_closed_reg         <= size_closed_next;
            size_bad_reg            <= size_bad_next;
            type_byte_reg           <= type_byte_next;
        end
    end

    // Payload phase always has blocks left to skip
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tarhw_pkg::PH_PAYLOAD) |-> (payload_blocks_left_reg != '0))
        else $error("payload phase with no blocks left");

    // Two results only as regular entry followed by end of input
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && results.count == 2'd2) |->
            (results.r0.kind == tarhw_pkg::KIND_REGULAR
             && results.r1.kind == tarhw_pkg::KIND_INPUT_END))
        else $error("bad result pair");

    // Final byte returns the walker to its reset state
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_input) |=>
            (byte_in_block_reg == '0 && stream_position_reg == '0
             && phase_reg == tarhw_pkg::PH_HEADER))
        else $error("walker not re-armed after final byte");

    // Position frozen once the archive has ended
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tarhw_pkg::PH_DONE && !(accept && end_of_input)) |=>
            $stable(stream_position_reg))
        else $error("position moved after archive end");

endmodule

### rtl/tarhw_outq.sv
module tarhw_outq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_en,
    input  tarhw_pkg::res_pair_t push,
    output logic                 ready,
    output logic                 head_valid,
    input  logic                 head_ready,
    output tarhw_pkg::result_t   head
);

    tarhw_pkg::result_t ent_reg [3];
    tarhw_pkg::result_t ent_next [3];
    logic [1:0]         count_reg, count_next;
    logic               pop;
    logic [1:0]         cnt;

    assign head_valid = (count_reg != 2'd0);
    assign head       = ent_reg[0];
    assign pop        = head_valid && head_ready;
    // Room for the two results one byte can cause
    assign ready      = (count_reg <= 2'd1);

    // Shift out the head, then append new results
    always_comb
    begin
        ent_next = ent_reg;
        cnt      = count_reg;
        if (pop)
        begin
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
            cnt         = count_reg - 2'd1;
        end
        count_next = cnt;
        if (push_en)
        begin
            if (push.count != 2'd0)
                ent_next[cnt] = push.r0;
            if (push.count == 2'd2)
                ent_next[cnt + 2'd1] = push.r1;
            count_next = cnt + push.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

### rtl/tar_header_walker_top.sv
// A result is registered in the output queue and presented on the master side from there.
// Throughput: one byte per cycle while results are taken; a byte that causes two results
// leaves two waiting in the queue, so the input holds off until one of them has drained.
// Input is taken while at most one result waits in the queue.
// Reset (rst_n low, asynchronous): walker at the start of a header, offset zero, queue empty.
module tar_header_walker_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [2:0] record_kind, [42:3] entry_offset,
                                        // [78:43] entry_size, [79] zero
    output logic        m_axis_tlast    // last_of_run
);

    logic                 accept;
    tarhw_pkg::res_pair_t results;
    tarhw_pkg::result_t   head;

    assign accept = s_axis_tvalid && s_axis_tready;

    tarhw_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_axis_tdata),
        .end_of_input (s_axis_tlast),
        .results      (results)
    );

    tarhw_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (accept),
        .push       (results),
        .ready      (s_axis_tready),
        .head_valid (m_axis_tvalid),
        .head_ready (m_axis_tready),
        .head       (head)
    );

    // Pack result transaction
    assign m_axis_tdata = {1'b0, head.size, head.offset, head.kind};
    assign m_axis_tlast = head.last;

endmodule
